### hw/rtl/pbt_pkg.sv
// ----------------------------------------------------------------------------
// Phase boundary tracker package
// Shared constants, codes, command and status types, the sigmoid knot table.
// ----------------------------------------------------------------------------
`default_nettype none

package pbt_pkg;

   localparam int SEGMENTS   = 256;
   localparam int SEG_SHIFT  = $clog2(SEGMENTS);
   localparam int ARG_BITS   = 19;
   localparam int KNOT_COUNT = SEGMENTS + 3;
   localparam int IDX_W      = $clog2(KNOT_COUNT);
   localparam int DIV_W      = 35;
   localparam int CNT_W      = $clog2(DIV_W);
   localparam int TAYLOR     = 24;

   localparam logic [16:0] HALF_Q16 = 17'd32768;
   localparam logic [16:0] ONE_Q16  = 17'd65536;

   localparam logic [2:0] CSR_REF_DEEP      = 3'd0;
   localparam logic [2:0] CSR_REF_SHALLOW   = 3'd1;
   localparam logic [2:0] CSR_SLOPE_DEEP    = 3'd2;
   localparam logic [2:0] CSR_SLOPE_SHALLOW = 3'd3;
   localparam logic [2:0] CSR_TT_DEEP       = 3'd4;
   localparam logic [2:0] CSR_TT_SHALLOW    = 3'd5;
   localparam logic [2:0] CSR_SHARP_DEEP    = 3'd6;
   localparam logic [2:0] CSR_SHARP_SHALLOW = 3'd7;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_MUL1, OP_MUL2, OP_SAT, OP_KNOT, OP_Q1, OP_Q2, OP_Q3,
      OP_FIN, OP_TRK, OP_DIVW, OP_COMMIT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_SAT, ST_KNOT, ST_Q1, ST_Q2, ST_Q3, ST_FIN,
      ST_TRK, ST_DIVW, ST_COMMIT
   } state_type;

   typedef struct packed {
      op_type op;
      logic   sel;
   } cmd_type;

   typedef struct packed {
      logic trk_div;
      logic div_done;
      logic out_free;
   } status_type;

   typedef logic [16:0] knot_table_type [0:KNOT_COUNT-1];

   function automatic longint unsigned div_u64(input longint unsigned num,
                                               input longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r    = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic knot_table_type build_knots();
      knot_table_type    tbl;
      longint unsigned   s;
      longint unsigned   tq;
      longint unsigned   term;
      longint unsigned   den;
      longint unsigned   x;
      longint unsigned   d;
      longint            sm;
      longint unsigned   one30;
      one30 = 64'd1 << 30;
      s = 64'(SEGMENTS);
      for (int i = 0; i < KNOT_COUNT; i++) begin
         tq   = ((64'(i) << 30) + (s >> 1)) >> SEG_SHIFT;
         term = one30;
         sm   = longint'(one30);
         for (int k = 1; k <= TAYLOR; k++) begin
            den  = 64'(k) << 30;
            term = div_u64(term * tq + (den >> 1), den);
            if (k[0]) begin
               sm = sm - longint'(term);
            end else begin
               sm = sm + longint'(term);
            end
         end
         if (sm < 0) begin
            sm = 0;
         end
         if (sm > longint'(one30)) begin
            sm = longint'(one30);
         end
         x = longint'(sm);
         for (int n = 0; n < 4; n++) begin
            x = (x * x + (one30 >> 1)) >> 30;
         end
         d = one30 + x;
         tbl[i] = 17'(div_u64((64'd1 << 46) + (d >> 1), d));
      end
      return tbl;
   endfunction

   localparam knot_table_type KNOTS = build_knots();

endpackage

`default_nettype wire

### hw/rtl/pbt_div.sv
// ----------------------------------------------------------------------------
// Phase boundary tracker divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pbt_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [pbt_pkg::DIV_W-1:0] dividend,
   input  wire logic [16:0]               divisor,
   output logic      [pbt_pkg::DIV_W-1:0] quotient,
   output logic                           done
);

   logic [pbt_pkg::DIV_W-1:0] quo_ff;
   logic [16:0]               rem_ff;
   logic [16:0]               den_ff;
   logic [pbt_pkg::CNT_W-1:0] cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic [17:0]               trial_in;
   logic                      fit_in;

   assign trial_in = {rem_ff, quo_ff[pbt_pkg::DIV_W-1]};
   assign fit_in   = trial_in >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == pbt_pkg::CNT_W'(pbt_pkg::DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + pbt_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fit_in ? 17'(trial_in - {1'b0, den_ff}) : trial_in[16:0];
         quo_ff <= {quo_ff[pbt_pkg::DIV_W-2:0], fit_in};
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

### hw/rtl/pbt_ctrl.sv
// ----------------------------------------------------------------------------
// Phase boundary tracker controller
// Sequences the datapath through both boundaries, tracking and the commit.
// ----------------------------------------------------------------------------
`default_nettype none

module pbt_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire pbt_pkg::status_type status,
   output pbt_pkg::cmd_type         cmd
);

   pbt_pkg::state_type state_ff;
   pbt_pkg::state_type state_in;
   logic               sel_ff;
   logic               sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbt_pkg::ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         pbt_pkg::ST_IDLE: begin
            sel_in = 1'b0;
            if (req_valid) begin
               state_in = pbt_pkg::ST_MUL1;
            end
         end
         pbt_pkg::ST_MUL1: state_in = pbt_pkg::ST_MUL2;
         pbt_pkg::ST_MUL2: state_in = pbt_pkg::ST_SAT;
         pbt_pkg::ST_SAT:  state_in = pbt_pkg::ST_KNOT;
         pbt_pkg::ST_KNOT: state_in = pbt_pkg::ST_Q1;
         pbt_pkg::ST_Q1:   state_in = pbt_pkg::ST_Q2;
         pbt_pkg::ST_Q2:   state_in = pbt_pkg::ST_Q3;
         pbt_pkg::ST_Q3:   state_in = pbt_pkg::ST_FIN;
         pbt_pkg::ST_FIN:  state_in = pbt_pkg::ST_TRK;
         pbt_pkg::ST_TRK: begin
            if (status.trk_div) begin
               state_in = pbt_pkg::ST_DIVW;
            end else if (sel_ff) begin
               state_in = pbt_pkg::ST_COMMIT;
            end else begin
               state_in = pbt_pkg::ST_MUL1;
               sel_in   = 1'b1;
            end
         end
         pbt_pkg::ST_DIVW: begin
            if (status.div_done) begin
               if (sel_ff) begin
                  state_in = pbt_pkg::ST_COMMIT;
               end else begin
                  state_in = pbt_pkg::ST_MUL1;
                  sel_in   = 1'b1;
               end
            end
         end
         pbt_pkg::ST_COMMIT: begin
            if (status.out_free) begin
               state_in = pbt_pkg::ST_IDLE;
            end
         end
         default: state_in = pbt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.sel   = sel_ff;
      cmd.op    = pbt_pkg::OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         pbt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.op    = req_valid ? pbt_pkg::OP_LOAD : pbt_pkg::OP_NONE;
         end
         pbt_pkg::ST_MUL1:   cmd.op = pbt_pkg::OP_MUL1;
         pbt_pkg::ST_MUL2:   cmd.op = pbt_pkg::OP_MUL2;
         pbt_pkg::ST_SAT:    cmd.op = pbt_pkg::OP_SAT;
         pbt_pkg::ST_KNOT:   cmd.op = pbt_pkg::OP_KNOT;
         pbt_pkg::ST_Q1:     cmd.op = pbt_pkg::OP_Q1;
         pbt_pkg::ST_Q2:     cmd.op = pbt_pkg::OP_Q2;
         pbt_pkg::ST_Q3:     cmd.op = pbt_pkg::OP_Q3;
         pbt_pkg::ST_FIN:    cmd.op = pbt_pkg::OP_FIN;
         pbt_pkg::ST_TRK:    cmd.op = pbt_pkg::OP_TRK;
         pbt_pkg::ST_DIVW:   cmd.op = pbt_pkg::OP_DIVW;
         pbt_pkg::ST_COMMIT: begin
            cmd.op = status.out_free ? pbt_pkg::OP_COMMIT : pbt_pkg::OP_NONE;
         end
         default: cmd.op = pbt_pkg::OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/pbt_datapath.sv
// ----------------------------------------------------------------------------
// Phase boundary tracker datapath
// Configuration registers, phase fraction arithmetic, column tracking and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbt_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pbt_pkg::cmd_type  cmd,
   output pbt_pkg::status_type    status,
   input  wire logic              csr_write,
   input  wire logic [2:0]        csr_index,
   input  wire logic [17:0]       csr_wdata,
   input  wire logic [16:0]       req_node_height,
   input  wire logic [15:0]       req_node_temp,
   input  wire logic              req_last_in_column,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [16:0]            rsp_frac_deep,
   output logic [16:0]            rsp_frac_shallow,
   output logic                   rsp_column_done,
   output logic [16:0]            rsp_cross_deep,
   output logic [16:0]            rsp_cross_shallow
);

   function automatic logic signed [21:0] rnd14(input logic signed [35:0] v);
      logic [35:0]        m;
      logic signed [21:0] r;
      m = v[35] ? 36'(-v) : 36'(v);
      m = (m + 36'd8192) >> 14;
      r = signed'(m[21:0]);
      return v[35] ? -r : r;
   endfunction

   function automatic logic signed [31:0] rnd8(input logic signed [39:0] v);
      logic [39:0]        m;
      logic signed [31:0] r;
      m = v[39] ? 40'(-v) : 40'(v);
      m = (m + 40'd128) >> 8;
      r = signed'(m[31:0]);
      return v[39] ? -r : r;
   endfunction

   function automatic logic signed [24:0] rnd39(input logic signed [63:0] v);
      logic [63:0]        m;
      logic signed [24:0] r;
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << 38)) >> 39;
      r = signed'(m[24:0]);
      return v[63] ? -r : r;
   endfunction

   logic [16:0]        zref_ff  [2];
   logic signed [17:0] slope_ff [2];
   logic [15:0]        tt_ff    [2];
   logic [15:0]        sharp_ff [2];

   logic [16:0]        h_ff;
   logic [15:0]        temp_ff;
   logic               last_ff;

   logic signed [35:0] prod1_ff;
   logic signed [39:0] prod2_ff;
   logic [19:0]        mag_ff;
   logic               neg_ff;
   logic [16:0]        f0_ff;
   logic signed [17:0] d1_ff;
   logic signed [18:0] d2_ff;
   logic [18:0]        rem_ff;
   logic signed [39:0] qa_ff;
   logic signed [63:0] acc_ff;
   logic [16:0]        frac_ff [2];

   logic [16:0]        prev_h_ff;
   logic [16:0]        prev_f_ff [2];
   logic               have_prev_ff;
   logic               found_ff [2];
   logic [16:0]        held_ff [2];
   logic               dneg_ff;

   logic               rsp_valid_ff;
   logic [16:0]        rsp_fd_ff;
   logic [16:0]        rsp_fs_ff;
   logic               rsp_done_ff;
   logic [16:0]        rsp_cd_ff;
   logic [16:0]        rsp_cs_ff;

   logic signed [16:0] dt_in;
   logic signed [21:0] cterm_in;
   logic signed [22:0] e_in;
   logic signed [31:0] arg_in;
   logic [31:0]        t_in;
   logic [pbt_pkg::IDX_W-1:0] idx_in;
   logic [pbt_pkg::IDX_W-1:0] idx1_in;
   logic [pbt_pkg::IDX_W-1:0] idx2_in;
   logic [16:0]        k0_in;
   logic [16:0]        k1_in;
   logic [16:0]        k2_in;
   logic signed [24:0] corr_in;
   logic signed [25:0] p_in;
   logic [16:0]        pc_in;
   logic [16:0]        pf_in;
   logic [16:0]        fc_in;
   logic               hit_in;
   logic               div_start_in;
   logic signed [17:0] dh_in;
   logic [16:0]        dmag_in;
   logic [32:0]        num_in;
   logic [16:0]        den_in;
   logic [pbt_pkg::DIV_W-1:0] dividend_in;
   logic [pbt_pkg::DIV_W-1:0] quotient;
   logic               div_done;
   logic signed [18:0] q_in;
   logic signed [18:0] cross_in;
   logic               s;

   assign s = cmd.sel;

   always_comb begin
      dt_in    = $signed({1'b0, temp_ff}) - $signed({1'b0, tt_ff[s]});
      cterm_in = rnd14(prod1_ff);
      e_in     = $signed({6'b0, zref_ff[s]}) - $signed({6'b0, h_ff}) - 23'(cterm_in);
      arg_in   = rnd8(prod2_ff);
      t_in     = {12'b0, mag_ff} * 32'(pbt_pkg::SEGMENTS);
      idx_in   = pbt_pkg::IDX_W'(t_in >> pbt_pkg::ARG_BITS);
      idx1_in  = idx_in + pbt_pkg::IDX_W'(1);
      idx2_in  = idx_in + pbt_pkg::IDX_W'(2);
      k0_in    = pbt_pkg::KNOTS[idx_in];
      k1_in    = pbt_pkg::KNOTS[idx1_in];
      k2_in    = pbt_pkg::KNOTS[idx2_in];
      corr_in  = rnd39(acc_ff);
      p_in     = $signed({9'b0, f0_ff}) + 26'(corr_in);
      if (p_in < 0) begin
         pc_in = '0;
      end else if (p_in > $signed({9'b0, pbt_pkg::ONE_Q16})) begin
         pc_in = pbt_pkg::ONE_Q16;
      end else begin
         pc_in = p_in[16:0];
      end
      pf_in   = prev_f_ff[s];
      fc_in   = frac_ff[s];
      hit_in  = have_prev_ff && !found_ff[s] && (pf_in >= pbt_pkg::HALF_Q16)
                && (fc_in <= pbt_pkg::HALF_Q16);
      dh_in   = $signed({1'b0, h_ff}) - $signed({1'b0, prev_h_ff});
      dmag_in = dh_in[17] ? 17'(-dh_in) : dh_in[16:0];
      num_in  = {16'b0, dmag_in} * {17'b0, 16'(pf_in - pbt_pkg::HALF_Q16)};
      den_in  = pf_in - fc_in;
      dividend_in  = pbt_pkg::DIV_W'(num_in) + pbt_pkg::DIV_W'(den_in >> 1);
      div_start_in = (cmd.op == pbt_pkg::OP_TRK) && hit_in && (pf_in != fc_in);
      q_in     = dneg_ff ? -$signed({1'b0, quotient[17:0]}) : $signed({1'b0, quotient[17:0]});
      cross_in = $signed({2'b0, prev_h_ff}) + q_in;
   end

   pbt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_in),
      .dividend (dividend_in),
      .divisor  (den_in),
      .quotient (quotient),
      .done     (div_done)
   );

   assign status.trk_div  = hit_in && (pf_in != fc_in);
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         zref_ff[0]  <= '0;
         zref_ff[1]  <= '0;
         slope_ff[0] <= '0;
         slope_ff[1] <= '0;
         tt_ff[0]    <= '0;
         tt_ff[1]    <= '0;
         sharp_ff[0] <= 16'd256;
         sharp_ff[1] <= 16'd256;
      end else if (csr_write) begin
         case (csr_index)
            pbt_pkg::CSR_REF_DEEP:      zref_ff[0]  <= csr_wdata[16:0];
            pbt_pkg::CSR_REF_SHALLOW:   zref_ff[1]  <= csr_wdata[16:0];
            pbt_pkg::CSR_SLOPE_DEEP:    slope_ff[0] <= signed'(csr_wdata);
            pbt_pkg::CSR_SLOPE_SHALLOW: slope_ff[1] <= signed'(csr_wdata);
            pbt_pkg::CSR_TT_DEEP:       tt_ff[0]    <= csr_wdata[15:0];
            pbt_pkg::CSR_TT_SHALLOW:    tt_ff[1]    <= csr_wdata[15:0];
            pbt_pkg::CSR_SHARP_DEEP:    sharp_ff[0] <= csr_wdata[15:0];
            pbt_pkg::CSR_SHARP_SHALLOW: sharp_ff[1] <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         pbt_pkg::OP_LOAD: begin
            h_ff    <= req_node_height;
            temp_ff <= req_node_temp;
            last_ff <= req_last_in_column;
         end
         pbt_pkg::OP_MUL1: prod1_ff <= 36'(slope_ff[s] * dt_in);
         pbt_pkg::OP_MUL2: prod2_ff <= 40'($signed({1'b0, sharp_ff[s]}) * e_in);
         pbt_pkg::OP_SAT: begin
            if (arg_in > 32'sd524288) begin
               mag_ff <= 20'd524288;
               neg_ff <= 1'b0;
            end else if (arg_in < -32'sd524288) begin
               mag_ff <= 20'd524288;
               neg_ff <= 1'b1;
            end else begin
               mag_ff <= arg_in[31] ? 20'(-arg_in) : arg_in[19:0];
               neg_ff <= arg_in[31];
            end
         end
         pbt_pkg::OP_KNOT: begin
            f0_ff  <= k0_in;
            d1_ff  <= $signed({1'b0, k1_in}) - $signed({1'b0, k0_in});
            d2_ff  <= $signed({2'b0, k2_in}) - $signed({1'b0, k1_in, 1'b0})
                      + $signed({2'b0, k0_in});
            rem_ff <= t_in[18:0];
         end
         pbt_pkg::OP_Q1: begin
            qa_ff  <= 40'($signed({1'b0, rem_ff})
                      * ($signed({2'b0, rem_ff}) - 21'sd524288));
            acc_ff <= 64'($signed({1'b0, rem_ff}) * d1_ff) <<< 20;
         end
         pbt_pkg::OP_Q2: begin
            acc_ff <= acc_ff + 64'($signed({1'b0, qa_ff[19:0]}) * d2_ff);
         end
         pbt_pkg::OP_Q3: begin
            acc_ff <= acc_ff + (64'($signed(qa_ff[39:20]) * d2_ff) <<< 20);
         end
         pbt_pkg::OP_FIN: frac_ff[s] <= neg_ff ? 17'(pbt_pkg::ONE_Q16 - pc_in) : pc_in;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_h_ff    <= '0;
         prev_f_ff[0] <= '0;
         prev_f_ff[1] <= '0;
         have_prev_ff <= 1'b0;
         found_ff[0]  <= 1'b0;
         found_ff[1]  <= 1'b0;
         held_ff[0]   <= '0;
         held_ff[1]   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == pbt_pkg::OP_COMMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            pbt_pkg::OP_TRK: begin
               if (hit_in) begin
                  found_ff[s] <= 1'b1;
                  if (pf_in == fc_in) begin
                     held_ff[s] <= prev_h_ff;
                  end
               end
               dneg_ff <= dh_in[17];
            end
            pbt_pkg::OP_DIVW: begin
               if (div_done) begin
                  held_ff[s] <= cross_in[16:0];
               end
            end
            pbt_pkg::OP_COMMIT: begin
               rsp_fd_ff    <= frac_ff[0];
               rsp_fs_ff    <= frac_ff[1];
               rsp_done_ff  <= last_ff;
               rsp_cd_ff    <= last_ff ? held_ff[0] : 17'd0;
               rsp_cs_ff    <= last_ff ? held_ff[1] : 17'd0;
               prev_h_ff    <= h_ff;
               prev_f_ff[0] <= frac_ff[0];
               prev_f_ff[1] <= frac_ff[1];
               have_prev_ff <= !last_ff;
               if (last_ff) begin
                  found_ff[0] <= 1'b0;
                  found_ff[1] <= 1'b0;
                  held_ff[0]  <= '0;
                  held_ff[1]  <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frac_deep     = rsp_fd_ff;
   assign rsp_frac_shallow  = rsp_fs_ff;
   assign rsp_column_done   = rsp_done_ff;
   assign rsp_cross_deep    = rsp_cd_ff;
   assign rsp_cross_shallow = rsp_cs_ff;

endmodule

`default_nettype wire

### hw/rtl/phase_boundary_tracker.sv
// ----------------------------------------------------------------------------
// Phase boundary tracker
// A node runs the shared multiply sequence once per boundary; each boundary
// whose crossing needs interpolating also waits on the bit-serial divider.
// A new node is taken only after the previous one is committed, and the
// commit waits while a stalled result is still held.
// Reset is synchronous; it restores the register defaults and clears the column.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_boundary_tracker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [17:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [16:0] req_node_height,
   input  wire logic [15:0] req_node_temp,
   input  wire logic        req_last_in_column,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [16:0]      rsp_frac_deep,
   output logic [16:0]      rsp_frac_shallow,
   output logic             rsp_column_done,
   output logic [16:0]      rsp_cross_deep,
   output logic [16:0]      rsp_cross_shallow
);

   pbt_pkg::cmd_type    cmd;
   pbt_pkg::status_type status;

   pbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pbt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_node_height    (req_node_height),
      .req_node_temp      (req_node_temp),
      .req_last_in_column (req_last_in_column),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frac_deep      (rsp_frac_deep),
      .rsp_frac_shallow   (rsp_frac_shallow),
      .rsp_column_done    (rsp_column_done),
      .rsp_cross_deep     (rsp_cross_deep),
      .rsp_cross_shallow  (rsp_cross_shallow)
   );

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input transfer not followed by busy");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_column_done) |-> (rsp_cross_deep == 17'd0 && rsp_cross_shallow == 17'd0))
      else $error("crossing height given before column end");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pbt_pkg::OP_COMMIT) |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire
